[rtl/bls_pkg.sv]
// Package for the bounded list store: command and status codes, the
// per-cell control struct and the fixed field widths.
// No dependencies.
`default_nettype none

package bls_pkg;

  // Fixed field widths of the command and response transactions
  localparam int unsigned WordW  = 32;
  localparam int unsigned IndexW = 6;
  localparam int unsigned FillW  = 7;

  // Read tree shape: the index reaches 64 positions, 8 groups of 8
  localparam int unsigned GrpW   = 3;
  localparam int unsigned GrpN   = 8;
  localparam int unsigned IdxSpan = 64;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_GET    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Per-cell update control, decoded at the top level
  typedef struct packed {
    logic load;   // take the pushed word
    logic shift;  // take the right-hand neighbour's word
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/bls_if.sv]
// Valid/ready channel interfaces for the command and response transactions.
// Depends on bls_pkg for the code types and field widths.
`default_nettype none

interface bls_cmd_if;
  logic                              valid;
  logic                              ready;
  bls_pkg::kind_e                    kind;
  logic signed [bls_pkg::WordW-1:0]  value;
  logic        [bls_pkg::IndexW-1:0] index;

  modport source (output valid, output kind, output value, output index, input ready);
  modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

interface bls_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [bls_pkg::WordW-1:0]  read_data;
  bls_pkg::status_e                  status;
  logic        [bls_pkg::FillW-1:0]  fill;

  modport source (output valid, output read_data, output status, output fill, input ready);
  modport sink   (input valid, input read_data, input status, input fill, output ready);
endinterface

`default_nettype wire

[rtl/bls_cell.sv]
// One storage cell of the list: holds a single word and passes it to its
// left-hand neighbour for the remove shift. Depends on bls_pkg.
`default_nettype none

module bls_cell (
  input  wire logic                             clk_i,
  input  wire bls_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic [bls_pkg::WordW-1:0]        push_word_i,
  input  wire logic [bls_pkg::WordW-1:0]        right_word_i,
  output logic      [bls_pkg::WordW-1:0]        word_o
);
  import bls_pkg::*;

  logic [WordW-1:0] word_d, word_q;

  // Push writes, remove shifts down from the right; otherwise hold
  always_comb begin
    word_d = word_q;
    if (ctrl_i.load) begin
      word_d = push_word_i;
    end else if (ctrl_i.shift) begin
      word_d = right_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

[rtl/bls_rd_tree.sv]
// Two-level registered read selection over the addressable cells:
// eight groups of eight words, then one group. Depends on bls_pkg.
`default_nettype none

module bls_rd_tree #(
  parameter int unsigned RD_N = 64
) (
  input  wire logic                          clk_i,
  input  wire logic [bls_pkg::WordW-1:0]     words_i [RD_N],
  input  wire logic [bls_pkg::IndexW-1:0]    index_i,
  output logic      [bls_pkg::WordW-1:0]     data_o
);
  import bls_pkg::*;

  logic [WordW-1:0] pad_w [IdxSpan];
  logic [WordW-1:0] grp_q [GrpN];
  logic [GrpW-1:0]  grp_sel_q;

  // Positions beyond the readable cells read as zero
  for (genvar p = 0; p < IdxSpan; p++) begin : g_pad
    if (p < RD_N) begin : g_live
      assign pad_w[p] = words_i[p];
    end else begin : g_zero
      assign pad_w[p] = '0;
    end
  end

  // First level: pick one word inside every group
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < GrpN; g++) begin
      grp_q[g[GrpW-1:0]] <= pad_w[{g[GrpW-1:0], index_i[GrpW-1:0]}];
    end
    grp_sel_q <= index_i[IndexW-1:GrpW];
  end

  // Second level: pick the group
  assign data_o = grp_q[grp_sel_q];

endmodule

`default_nettype wire

[rtl/bounded_list_store.sv]
// Top level of the bounded list store: command decode, the row of cells,
// read tree and response register. Depends on bls_pkg, bls_if, bls_cell,
// bls_rd_tree.
//
// Usage:
//   cmd_i carries one command per transaction (kind, value, index);
//   rsp_o returns exactly one response per command (read_data, status,
//   fill), in command order. Both are valid/ready channels.
//   Each accepted command passes through the command stage register
//   (busy_q, with the first read-tree level) and then the response
//   register before its response is valid. A command is taken only
//   while no other command is in flight.
//   Push and remove update the row of cells in the accept cycle (pop only
//   lowers the fill); remove moves every later word one cell down at once.
//   The response register holds while rsp_o is stalled; cmd_i.ready stays
//   low until the held response is taken (it may be taken in the same
//   cycle as the next command).
//   Reset empties the list (fill 0) and clears the channel state; the
//   stored words are not cleared and are never read before being written.
`default_nettype none

module bounded_list_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bls_cmd_if.sink   cmd_i,
  bls_rsp_if.source rsp_o
);
  import bls_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > IndexW) ? CntW : IndexW;
  localparam int unsigned RdN  = (CAPACITY < IdxSpan) ? CAPACITY : IdxSpan;

  logic            accept_w;
  logic            busy_q;
  logic [CntW-1:0] used_d, used_q;
  status_e         st_d, st_q;
  logic            get_ok_d, get_ok_q;
  logic            push_ok_w, remove_ok_w;
  logic            in_range_w;
  logic [CmpW-1:0] index_ext_w;

  logic             out_valid_q;
  logic [WordW-1:0] out_data_q;
  status_e          out_st_q;
  logic [FillW-1:0] out_fill_q;

  cell_ctrl_t       ctrl_w [CAPACITY];
  logic [WordW-1:0] word_w [CAPACITY];
  logic [WordW-1:0] rd_words_w [RdN];
  logic [WordW-1:0] tree_data_w;

  // One command at a time; the response slot must be free or emptying
  assign cmd_i.ready = !busy_q && (!out_valid_q || rsp_o.ready);
  assign accept_w    = cmd_i.valid && cmd_i.ready;

  assign index_ext_w = CmpW'(cmd_i.index);
  assign in_range_w  = index_ext_w < CmpW'(used_q);

  // Status and new fill count
  always_comb begin
    used_d      = used_q;
    st_d        = ST_OK;
    get_ok_d    = 1'b0;
    push_ok_w   = 1'b0;
    remove_ok_w = 1'b0;
    case (cmd_i.kind)
      KIND_PUSH: begin
        if (used_q == CntW'(CAPACITY)) begin
          st_d = ST_FULL;
        end else begin
          push_ok_w = 1'b1;
          used_d    = used_q + 1'b1;
        end
      end
      KIND_POP: begin
        if (used_q == '0) begin
          st_d = ST_EMPTY;
        end else begin
          used_d = used_q - 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (!in_range_w) begin
          st_d = ST_RANGE;
        end else begin
          remove_ok_w = 1'b1;
          used_d      = used_q - 1'b1;
        end
      end
      KIND_GET: begin
        if (!in_range_w) begin
          st_d = ST_RANGE;
        end else begin
          get_ok_d = 1'b1;
        end
      end
      default: st_d = ST_OK;
    endcase
  end

  // Command stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      used_q   <= '0;
      st_q     <= ST_OK;
      get_ok_q <= 1'b0;
    end else begin
      busy_q <= accept_w;
      if (accept_w) begin
        used_q   <= used_d;
        st_q     <= st_d;
        get_ok_q <= get_ok_d;
      end
    end
  end

  // Row of cells with per-position decode
  for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
    assign ctrl_w[c].load  = accept_w && push_ok_w && (used_q == CntW'(c));
    assign ctrl_w[c].shift = accept_w && remove_ok_w && (CmpW'(c) >= index_ext_w)
                             && (CntW'(c + 1) < used_q);

    if (c + 1 < CAPACITY) begin : g_mid
      bls_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl_w[c]),
        .push_word_i (cmd_i.value),
        .right_word_i(word_w[c + 1]),
        .word_o      (word_w[c])
      );
    end else begin : g_last
      bls_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl_w[c]),
        .push_word_i (cmd_i.value),
        .right_word_i('0),
        .word_o      (word_w[c])
      );
    end
  end

  for (genvar r = 0; r < RdN; r++) begin : g_rd
    assign rd_words_w[r] = word_w[r];
  end

  bls_rd_tree #(
    .RD_N(RdN)
  ) u_rd_tree (
    .clk_i  (clk_i),
    .words_i(rd_words_w),
    .index_i(cmd_i.index),
    .data_o (tree_data_w)
  );

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (busy_q) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      out_data_q <= get_ok_q ? tree_data_w : '0;
      out_st_q   <= st_q;
      out_fill_q <= FillW'(used_q);
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;
  assign rsp_o.status    = out_st_q;
  assign rsp_o.fill      = out_fill_q;

  // Checks
  a_busy_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !out_valid_q)
    else $error("response slot occupied while a command is in flight");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w |=> busy_q)
    else $error("accepted command did not enter the command stage");

  a_rsp_from_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("response appeared without a command");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for bounded_list_store: directed command table, then
// random push/pop/remove/get traffic checked against a behavioural list model.
// Depends on bls_pkg, bls_if and the bounded_list_store RTL.
`default_nettype none

module tb_top;
  import bls_pkg::*;

  localparam int unsigned LIST_DEPTH   = 64;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 310;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct {
    kind_e                    kind;
    logic signed [WordW-1:0]  value;
    logic        [IndexW-1:0] index;
    bit                       typed;   // expected reply below is given by hand
    logic signed [WordW-1:0]  data;
    status_e                  status;
    logic        [FillW-1:0]  fill;
  } list_cmd_row_t;

  typedef struct {
    logic signed [WordW-1:0] data;
    status_e                 status;
    logic        [FillW-1:0] fill;
  } list_reply_t;

  logic clk_i;
  logic rst_ni;

  bls_cmd_if cmd ();
  bls_rsp_if rsp ();

  bounded_list_store #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd.sink),
    .rsp_o (rsp.source)
  );

  // Shadow copy of the list contents
  logic signed [WordW-1:0] shadow_words [LIST_DEPTH];
  int unsigned             list_count;

  list_reply_t   expected_replies [$];
  list_cmd_row_t cmd_table [$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  int unsigned   items_sent;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Append one row to the directed command table
  function automatic void add_row(input list_cmd_row_t row);
    cmd_table.insert(cmd_table.size(), row);
  endfunction

  // Apply one command to the shadow list and return the reply it gives
  function automatic list_reply_t list_apply(input list_cmd_row_t row);
    list_reply_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (row.kind)
      KIND_PUSH: begin
        if (list_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[list_count[IndexW-1:0]] = row.value;
          list_count++;
        end
      end
      KIND_POP: begin
        if (list_count == 0) r.status = ST_EMPTY;
        else list_count--;
      end
      KIND_REMOVE: begin
        if (row.index >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = row.index; i + 1 < list_count; i++)
            shadow_words[i[IndexW-1:0]] = shadow_words[IndexW'(i + 1)];
          list_count--;
        end
      end
      default: begin
        if (row.index >= list_count) r.status = ST_RANGE;
        else r.data = shadow_words[row.index];
      end
    endcase
    r.fill = list_count[FillW-1:0];
    return r;
  endfunction

  // Drive one command transaction, with random idle cycles before it
  task automatic issue_cmd(input list_cmd_row_t row);
    list_reply_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      cmd.valid <= 1'b0;
    end
    @(negedge clk_i);
    cmd.valid <= 1'b1;
    cmd.kind  <= row.kind;
    cmd.value <= row.value;
    cmd.index <= row.index;
    do @(posedge clk_i); while (!cmd.ready);
    r = list_apply(row);
    if (row.typed) begin
      r.data   = row.data;
      r.status = row.status;
      r.fill   = row.fill;
    end
    expected_replies.insert(expected_replies.size(), r);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding reply
  task automatic hold_off();
    @(negedge clk_i);
    cmd.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [WordW-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a valid position; now and then any position
  function automatic logic [IndexW-1:0] pick_index();
    if (list_count == 0 || $urandom_range(99) < 15) return IndexW'($urandom_range(63));
    return IndexW'($urandom_range(list_count - 1));
  endfunction

  function automatic list_cmd_row_t rand_row(input kind_e k);
    list_cmd_row_t row;
    row.kind   = k;
    row.value  = pick_word();
    row.index  = (k == KIND_REMOVE || k == KIND_GET) ? pick_index()
                                                      : IndexW'($urandom_range(63));
    row.typed  = 1'b0;
    row.data   = '0;
    row.status = ST_OK;
    row.fill   = '0;
    return row;
  endfunction

  // One random sequence: fill to full, drain to empty, or a short mix
  task automatic run_sequence();
    int unsigned r;
    case ($urandom_range(3))
      0: begin
        while (list_count < LIST_DEPTH)
          issue_cmd(rand_row($urandom_range(9) == 0 ? KIND_GET : KIND_PUSH));
        repeat ($urandom_range(1, 2)) issue_cmd(rand_row(KIND_PUSH));
        repeat (3) issue_cmd(rand_row($urandom_range(1) ? KIND_GET : KIND_REMOVE));
      end
      1: begin
        while (list_count > 0) begin
          r = $urandom_range(99);
          if (r < 45)      issue_cmd(rand_row(KIND_POP));
          else if (r < 80) issue_cmd(rand_row(KIND_REMOVE));
          else             issue_cmd(rand_row(KIND_GET));
        end
        issue_cmd(rand_row(KIND_POP));
        issue_cmd(rand_row(KIND_GET));
      end
      default: begin
        repeat (20) begin
          r = $urandom_range(99);
          if (r < 35)      issue_cmd(rand_row(KIND_PUSH));
          else if (r < 50) issue_cmd(rand_row(KIND_POP));
          else if (r < 70) issue_cmd(rand_row(KIND_REMOVE));
          else             issue_cmd(rand_row(KIND_GET));
        end
      end
    endcase
  endtask

  // Receiver: ready toggles at the falling edge
  always @(negedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Reply checker
  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected reply: read_data %0d status %s fill %0d",
               rsp.read_data, rsp.status.name(), rsp.fill);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        if (rsp.read_data !== want.data) begin
          $error("read_data: expected %0d, got %0d", want.data, rsp.read_data);
          mismatch_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %s, got %s", want.status.name(), rsp.status.name());
          mismatch_count++;
        end
        if (rsp.fill !== want.fill) begin
          $error("fill: expected %0d, got %0d", want.fill, rsp.fill);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    cmd.valid      = 1'b0;
    cmd.kind       = KIND_PUSH;
    cmd.value      = '0;
    cmd.index      = '0;
    rst_ni         = 1'b0;
    list_count     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    items_sent     = 0;
    send_idle_pct  = 16;
    recv_idle_pct  = 53;
    foreach (shadow_words[i]) shadow_words[i] = '0;

    // Directed commands: empty-store errors, extreme words, bad positions,
    // remove at the middle, the end and the front, drain to empty, then push and get once more
    add_row('{KIND_POP,    0,              0, 1, 0, ST_EMPTY, 0});
    add_row('{KIND_GET,    0,              0, 1, 0, ST_RANGE, 0});
    add_row('{KIND_REMOVE, 0,             63, 1, 0, ST_RANGE, 0});
    add_row('{KIND_PUSH,   32'sh7fff_ffff, 0, 1, 0, ST_OK,    1});
    add_row('{KIND_PUSH,   32'sh8000_0000, 0, 1, 0, ST_OK,    2});
    add_row('{KIND_GET,    0,              0, 1, 32'sh7fff_ffff, ST_OK, 2});
    add_row('{KIND_GET,    0,              1, 1, 32'sh8000_0000, ST_OK, 2});
    add_row('{KIND_GET,    0,              2, 1, 0, ST_RANGE, 2});
    add_row('{KIND_GET,    -1,            63, 1, 0, ST_RANGE, 2});
    add_row('{KIND_PUSH,   -1,             0, 1, 0, ST_OK,    3});
    add_row('{KIND_PUSH,   0,             63, 1, 0, ST_OK,    4});
    add_row('{KIND_PUSH,   32'sh5a5a_5a5a, 0, 0, 0, ST_OK,    0});
    add_row('{KIND_REMOVE, 0,              1, 1, 0, ST_OK,    4});
    add_row('{KIND_GET,    0,              1, 0, 0, ST_OK,    0});
    add_row('{KIND_REMOVE, 0,              3, 1, 0, ST_OK,    3});
    add_row('{KIND_GET,    0,              2, 0, 0, ST_OK,    0});
    add_row('{KIND_REMOVE, -1,             0, 0, 0, ST_OK,    0});
    add_row('{KIND_GET,    32'sh1234_5678, 0, 0, 0, ST_OK,    0});
    add_row('{KIND_POP,    0,             42, 1, 0, ST_OK,    1});
    add_row('{KIND_POP,    0,              0, 1, 0, ST_OK,    0});
    add_row('{KIND_POP,    0,              0, 1, 0, ST_EMPTY, 0});
    add_row('{KIND_PUSH,   32'sh1234_5678, 63, 0, 0, ST_OK,   0});
    add_row('{KIND_GET,    32'sh7654_3210, 0, 0, 0, ST_OK,    0});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (cmd_table[i]) issue_cmd(cmd_table[i]);

    // Three phases of random traffic; each starts with a full store
    for (int ph = 0; ph < 3; ph++) begin
      hold_off();
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 53 : 0;
      recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 16 : 0;
      while (list_count < LIST_DEPTH) issue_cmd(rand_row(KIND_PUSH));
      issue_cmd(rand_row(KIND_PUSH));
      while (items_sent < cmd_table.size() + (ph + 1) * PHASE_ITEMS) run_sequence();
    end

    hold_off();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/bls_pkg.sv
rtl/bls_if.sv
rtl/bls_cell.sv
rtl/bls_rd_tree.sv
rtl/bounded_list_store.sv
sim/tb_top.sv
